// ===== hw/rtl/time_versioned_key_value_store_unit_assert.svh =====
// Assertion macros for the time versioned key value store.
`ifndef TIME_VERSIONED_KEY_VALUE_STORE_UNIT_ASSERT_SVH
`define TIME_VERSIONED_KEY_VALUE_STORE_UNIT_ASSERT_SVH

// Implication checked every clock, quiet during reset.
`define TVKV_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tvkv check failed");

// Next-cycle implication checked every clock, quiet during reset.
`define TVKV_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tvkv check failed");

`endif

// ===== hw/rtl/tvkv_pkg.sv =====
// ----------------------------------------------------------------------------
// tvkv_pkg
// Shared types and constants of the time versioned key value store.
// ----------------------------------------------------------------------------
`default_nettype none
package tvkv_pkg;
  localparam int KEY_SLOTS_DEF     = 128;
  localparam int PAIRS_PER_KEY_DEF = 64;

  typedef enum logic [0:0] {OP_SET = 1'b0, OP_GET = 1'b1} op_t;
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_KEYS_FULL = 2'd1,
    ST_LIST_FULL = 2'd2
  } status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/tvkv_key_table.sv =====
// ----------------------------------------------------------------------------
// tvkv_key_table
// Key tag and pair count memory; one entry read and one entry written per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module tvkv_key_table #(
  parameter int KEY_SLOTS = 128,
  parameter int CW        = 7
) (
  input  wire logic                         clk,
  input  wire logic                         rd_en,
  input  wire logic [$clog2(KEY_SLOTS)-1:0] rd_addr,
  output logic      [31:0]                  rd_tag,
  output logic      [CW-1:0]                rd_count,
  input  wire logic                         wr_en,
  input  wire logic [$clog2(KEY_SLOTS)-1:0] wr_addr,
  input  wire logic [31:0]                  wr_tag,
  input  wire logic [CW-1:0]                wr_count
);
  logic [31:0]   tags   [KEY_SLOTS];
  logic [CW-1:0] counts [KEY_SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tags[wr_addr]   <= wr_tag;
      counts[wr_addr] <= wr_count;
    end
    if (rd_en) begin
      rd_tag   <= tags[rd_addr];
      rd_count <= counts[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tvkv_pair_mem.sv =====
// ----------------------------------------------------------------------------
// tvkv_pair_mem
// Time and value memory for all stored pairs.
// ----------------------------------------------------------------------------
`default_nettype none
module tvkv_pair_mem #(
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [31:0]              rd_time,
  output logic      [31:0]              rd_value,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [31:0]              wr_time,
  input  wire logic [31:0]              wr_value
);
  logic [31:0] times  [DEPTH];
  logic [31:0] values [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      times[wr_addr]  <= wr_time;
      values[wr_addr] <= wr_value;
    end
    if (rd_en) begin
      rd_time  <= times[rd_addr];
      rd_value <= values[rd_addr];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/time_versioned_key_value_store_unit.sv =====
// ----------------------------------------------------------------------------
// time_versioned_key_value_store_unit
// Keyed store of timestamped values with floor lookup by bisection.
//
//  channel   handshake        ports
//  command   start / busy     operation key time_req value
//  result    done strobe      found result_value status
//
// Key search visits occupied slots in turn through S_SCAN and S_CHECK; a get
// then bisects the key's pairs, each probe through S_PROBE and S_EVAL (at most
// log2(PAIRS_PER_KEY)+1 probes), and fetches the floor pair through S_FINAL and
// S_WAITV; both memories have registered reads.
// Synchronous reset empties the key table at once; no clearing pass.
// The result strobe lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
module time_versioned_key_value_store_unit #(
  parameter int KEY_SLOTS     = tvkv_pkg::KEY_SLOTS_DEF,
  parameter int PAIRS_PER_KEY = tvkv_pkg::PAIRS_PER_KEY_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation,
  input  wire logic [31:0] key,
  input  wire logic [31:0] time_req,
  input  wire logic [31:0] value,
  output logic             done,
  output logic             found,
  output logic [31:0]      result_value,
  output logic [1:0]       status
);
  import tvkv_pkg::*;

  localparam int SW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
  localparam int PW = (PAIRS_PER_KEY > 1) ? $clog2(PAIRS_PER_KEY) : 1;
  localparam int KW = $clog2(KEY_SLOTS + 1);
  localparam int CW = $clog2(PAIRS_PER_KEY + 1);
  localparam int DEPTH = KEY_SLOTS * PAIRS_PER_KEY;
  localparam int AW = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
  localparam int IW = PW + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_CHECK, S_SET, S_PROBE, S_EVAL, S_FINAL, S_WAITV
  } state_t;

  state_t         state;
  logic [KW-1:0]  keys_used;
  logic [KW-1:0]  idx;
  logic           op_r;
  logic [31:0]    key_r, time_r, value_r;
  logic [SW-1:0]  slot;
  logic [CW-1:0]  cnt;
  logic signed [IW-1:0] lo, hi, best;
  logic [PW-1:0]  mid_r;
  logic           done_next;

  logic           kt_rd_en, kt_wr_en;
  logic [SW-1:0]  kt_rd_addr, kt_wr_addr;
  logic [31:0]    kt_rd_tag;
  logic [CW-1:0]  kt_rd_count, kt_wr_count;
  logic           pm_rd_en, pm_wr_en;
  logic [AW-1:0]  pm_rd_addr, pm_wr_addr;
  logic [31:0]    pm_rd_time, pm_rd_value;
  logic signed [IW-1:0] mid;

  tvkv_key_table #(.KEY_SLOTS(KEY_SLOTS), .CW(CW)) u_keys (
    .clk, .rd_en(kt_rd_en), .rd_addr(kt_rd_addr), .rd_tag(kt_rd_tag),
    .rd_count(kt_rd_count), .wr_en(kt_wr_en), .wr_addr(kt_wr_addr),
    .wr_tag(key_r), .wr_count(kt_wr_count)
  );

  tvkv_pair_mem #(.DEPTH(DEPTH)) u_pairs (
    .clk, .rd_en(pm_rd_en), .rd_addr(pm_rd_addr), .rd_time(pm_rd_time),
    .rd_value(pm_rd_value), .wr_en(pm_wr_en), .wr_addr(pm_wr_addr),
    .wr_time(time_r), .wr_value(value_r)
  );

  assign busy = (state != S_IDLE);
  assign mid  = lo + ((hi - lo) >>> 1);

  always_comb begin
    kt_rd_en    = (state == S_SCAN) && (idx < keys_used);
    kt_rd_addr  = idx[SW-1:0];
    kt_wr_en    = 1'b0;
    kt_wr_addr  = slot;
    kt_wr_count = CW'(cnt + 1'b1);
    pm_rd_en    = 1'b0;
    pm_rd_addr  = AW'(slot * PAIRS_PER_KEY + mid[PW-1:0]);
    pm_wr_en    = 1'b0;
    pm_wr_addr  = AW'(slot * PAIRS_PER_KEY + cnt);
    if (state == S_SET && cnt < CW'(PAIRS_PER_KEY)) begin
      kt_wr_en = 1'b1;
      pm_wr_en = 1'b1;
    end
    if (state == S_PROBE && lo <= hi) pm_rd_en = 1'b1;
    if (state == S_FINAL) begin
      pm_rd_en   = 1'b1;
      pm_rd_addr = AW'(slot * PAIRS_PER_KEY + best[PW-1:0]);
    end
  end

  always_comb begin
    case (state)
      S_SCAN: begin
        done_next = (idx >= keys_used) &&
                    (op_r == OP_GET || keys_used >= KW'(KEY_SLOTS));
      end
      S_SET, S_WAITV: done_next = 1'b1;
      S_PROBE: done_next = !(lo <= hi) && !(best >= 0);
      S_EVAL: done_next = (pm_rd_time == time_r);
      default: done_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      keys_used <= '0;
      done      <= 1'b0;
    end else begin
      done <= done_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_r    <= operation;
            key_r   <= key;
            time_r  <= time_req;
            value_r <= value;
            idx     <= '0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (idx < keys_used) begin
            state <= S_CHECK;
          end else if (op_r == OP_GET) begin
            found        <= 1'b0;
            result_value <= '0;
            status       <= ST_OK;
            state        <= S_IDLE;
          end else if (keys_used >= KW'(KEY_SLOTS)) begin
            found        <= 1'b0;
            result_value <= '0;
            status       <= ST_KEYS_FULL;
            state        <= S_IDLE;
          end else begin
            slot      <= keys_used[SW-1:0];
            cnt       <= '0;
            keys_used <= keys_used + 1'b1;
            state     <= S_SET;
          end
        end
        S_CHECK: begin
          if (kt_rd_tag == key_r) begin
            slot <= idx[SW-1:0];
            cnt  <= kt_rd_count;
            lo   <= '0;
            hi   <= IW'(kt_rd_count) - 1'sb1;
            best <= '1;
            state <= (op_r == OP_SET) ? S_SET : S_PROBE;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SCAN;
          end
        end
        S_SET: begin
          found        <= 1'b0;
          result_value <= '0;
          status       <= (cnt < CW'(PAIRS_PER_KEY)) ? ST_OK : ST_LIST_FULL;
          state        <= S_IDLE;
        end
        S_PROBE: begin
          if (lo <= hi) begin
            mid_r <= mid[PW-1:0];
            state <= S_EVAL;
          end else if (best >= 0) begin
            state <= S_FINAL;
          end else begin
            found        <= 1'b0;
            result_value <= '0;
            status       <= ST_OK;
            state        <= S_IDLE;
          end
        end
        S_EVAL: begin
          if (pm_rd_time == time_r) begin
            found        <= 1'b1;
            result_value <= pm_rd_value;
            status       <= ST_OK;
            state        <= S_IDLE;
          end else if ($signed(pm_rd_time) < $signed(time_r)) begin
            best  <= IW'(mid_r);
            lo    <= IW'(mid_r) + 1'sb1;
            state <= S_PROBE;
          end else begin
            hi    <= IW'(mid_r) - 1'sb1;
            state <= S_PROBE;
          end
        end
        S_FINAL: state <= S_WAITV;
        S_WAITV: begin
          found        <= 1'b1;
          result_value <= pm_rd_value;
          status       <= ST_OK;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/tvkv_checker.sv =====
// ----------------------------------------------------------------------------
// tvkv_port_checker
// Port-level checks of the time versioned key value store.
// ----------------------------------------------------------------------------
`default_nettype none
`include "time_versioned_key_value_store_unit_assert.svh"
module tvkv_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic        found,
  input wire logic [31:0] result_value,
  input wire logic [1:0]  status
);
  import tvkv_pkg::*;

  `TVKV_ASSERT_NXT(a_start_busy, clk, rst, start && !busy, busy)
  `TVKV_ASSERT_IMP(a_done_after_busy, clk, rst, done, $past(busy))
  `TVKV_ASSERT_IMP(a_miss_zero, clk, rst, done && !found, result_value == 32'd0)
  `TVKV_ASSERT_IMP(a_found_ok, clk, rst, done && found, status == ST_OK)
endmodule

bind time_versioned_key_value_store_unit tvkv_port_checker u_tvkv_checker (
  .clk, .rst, .start, .busy, .done, .found, .result_value, .status
);
`default_nettype wire
